// File: rtl/lbpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbpm_pkg: shared types and constants
// Request/result words, controller states and command bundles.
// ----------------------------------------------------------------------------
package lbpm_pkg;

    localparam int FRAMES   = 64;
    localparam int DB_SLOTS = 8;
    localparam int PIN_MAX  = 255;
    localparam int FW       = $clog2(FRAMES);
    localparam int LW       = $clog2(FRAMES + 1);
    localparam int PW       = $clog2(PIN_MAX + 1);
    localparam int TAGW     = 23;

    localparam logic [1:0] CMD_PIN   = 2'd0;
    localparam logic [1:0] CMD_UNPIN = 2'd1;
    localparam logic [1:0] CMD_FORCE = 2'd2;
    localparam logic [1:0] CMD_RSVD  = 2'd3;

    localparam logic [2:0] ST_DONE    = 3'd0;
    localparam logic [2:0] ST_FREE    = 3'd1;
    localparam logic [2:0] ST_EVICT   = 3'd2;
    localparam logic [2:0] ST_NOFRAME = 3'd3;
    localparam logic [2:0] ST_ABSENT  = 3'd4;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [2:0]  db_id;
        logic [19:0] block_id;
        logic        made_dirty;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  frame;
        logic        fetch_needed;
        logic        writeback;
        logic [2:0]  writeback_db;
        logic [19:0] writeback_block;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_LRUSCAN, S_POPRD, S_POPWAIT, S_EVRD,
        S_EVWAIT, S_RESULT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture request, reset scan
        logic scan_step;   // advance tag scan
        logic lru_step;    // advance LRU compaction
        logic lru_init;
        logic pop_rd;      // read head of chosen queue
        logic ev_rd;       // read victim tag
        logic commit;      // apply state updates, issue result
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
        logic lru_done;
        logic need_scan;   // request needs tag lookup
        logic need_lru;    // hit pin with count 0
        logic miss_pin;
        logic use_free;
        logic use_lru;
    } sts_t;

endpackage

// File: rtl/lru_buffer_pool_manager_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_buffer_pool_manager_top: LRU buffer pool frame manager
// Looks up, pins, unpins and forces blocks over a pool of frames.
// ----------------------------------------------------------------------------
// Usage:
//   Drive a request word on req and raise start while busy is low; the word
//   is taken at that edge. Exactly one result word follows on result, with
//   result_valid high for one cycle; the receiver cannot stall it.
//   The tag lookup walks the frame tag RAM one frame a cycle, stopping at
//   the first hit. A pin that hits an unpinned frame, and a pin that evicts,
//   then compact the LRU queue RAM one entry a cycle. result_valid rises in
//   the same cycle that busy falls; one request is in flight at a time. The
//   tag scan and LRU compaction, each through a single RAM read port, set
//   how long busy stays high.
//   Reset empties the LRU queue, fills the free queue and clears its head;
//   the free queue restarts at frame 0. A frame's pin count and dirty bit are
//   written when it is loaded, so the tag, pin count, dirty and LRU RAMs need no clear.
// ----------------------------------------------------------------------------
module lru_buffer_pool_manager_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  lbpm_pkg::req_t  req,
    output logic            result_valid,
    output lbpm_pkg::rsp_t  result
);

    lbpm_pkg::ctl_t ctl;
    lbpm_pkg::sts_t sts;

    lbpm_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sts(sts), .ctl(ctl)
    );

    lbpm_dp u_dp (
        .clk(clk), .rst_n(rst_n), .req(req), .ctl(ctl), .sts(sts),
        .result(result), .done(result_valid)
    );

endmodule

// File: rtl/lbpm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbpm_ram: generic single-port-write, single-read RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lbpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/lbpm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbpm_ctrl: request sequencer
// Steps each request through lookup, queue update and result.
// ----------------------------------------------------------------------------
module lbpm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  lbpm_pkg::sts_t    sts,
    output lbpm_pkg::ctl_t    ctl
);

    lbpm_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lbpm_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lbpm_pkg::S_IDLE:    if (start) state_next = lbpm_pkg::S_SCAN;
            lbpm_pkg::S_SCAN:
            begin
                if (!sts.need_scan) state_next = lbpm_pkg::S_RESULT;
                else if (sts.scan_done) state_next = lbpm_pkg::S_DECIDE;
            end
            lbpm_pkg::S_DECIDE:
            begin
                if (sts.need_lru) state_next = lbpm_pkg::S_LRUSCAN;
                else if (sts.miss_pin && (sts.use_free || sts.use_lru))
                    state_next = lbpm_pkg::S_POPRD;
                else state_next = lbpm_pkg::S_RESULT;
            end
            lbpm_pkg::S_LRUSCAN: if (sts.lru_done) state_next = lbpm_pkg::S_RESULT;
            lbpm_pkg::S_POPRD:   state_next = lbpm_pkg::S_POPWAIT;
            lbpm_pkg::S_POPWAIT:
            begin
                if (sts.use_free) state_next = lbpm_pkg::S_RESULT;
                else state_next = lbpm_pkg::S_EVRD;
            end
            lbpm_pkg::S_EVRD:    state_next = lbpm_pkg::S_EVWAIT;
            lbpm_pkg::S_EVWAIT:  state_next = lbpm_pkg::S_LRUSCAN;
            lbpm_pkg::S_RESULT:  state_next = lbpm_pkg::S_IDLE;
            default:             state_next = lbpm_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        ctl = '0;
        busy = (state_reg != lbpm_pkg::S_IDLE);
        case (state_reg)
            lbpm_pkg::S_IDLE:    ctl.load = start;
            lbpm_pkg::S_SCAN:    ctl.scan_step = 1'b1;
            lbpm_pkg::S_DECIDE:  ctl.lru_init = 1'b1;
            lbpm_pkg::S_LRUSCAN: ctl.lru_step = 1'b1;
            lbpm_pkg::S_POPRD:   ctl.pop_rd = 1'b1;
            lbpm_pkg::S_EVRD:    ctl.ev_rd = 1'b1;
            lbpm_pkg::S_EVWAIT:  ctl.lru_init = 1'b1;
            lbpm_pkg::S_RESULT:  ctl.commit = 1'b1;
            default:             ctl = '0;
        endcase
    end

endmodule

// File: rtl/lbpm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbpm_dp: buffer pool datapath
// Tag, pin count, dirty and LRU RAMs, free queue head, result register.
// ----------------------------------------------------------------------------
module lbpm_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  lbpm_pkg::req_t    req,
    input  lbpm_pkg::ctl_t    ctl,
    output lbpm_pkg::sts_t    sts,
    output lbpm_pkg::rsp_t    result,
    output logic              done
);

    localparam int FW = lbpm_pkg::FW;
    localparam int LW = lbpm_pkg::LW;
    localparam int PW = lbpm_pkg::PW;

    lbpm_pkg::req_t req_reg;
    logic [LW-1:0] scan_reg, lru_len_reg, rd_reg, wr_reg, free_len_reg, free_head_reg;
    logic          hit_reg;
    logic [FW-1:0] hit_frame_reg, vic_reg;
    logic [lbpm_pkg::TAGW-1:0] vic_tag_reg;
    logic          evict_reg;
    lbpm_pkg::rsp_t rsp_reg;
    logic          done_reg;

    // tag RAM
    logic          tag_we;
    logic [FW-1:0] tag_waddr, tag_raddr;
    logic [lbpm_pkg::TAGW-1:0] tag_rdata;
    lbpm_ram #(.WIDTH(lbpm_pkg::TAGW), .DEPTH(lbpm_pkg::FRAMES)) u_tag (
        .clk(clk), .we(tag_we), .waddr(tag_waddr),
        .wdata({req_reg.db_id, req_reg.block_id}),
        .raddr(tag_raddr), .rdata(tag_rdata)
    );

    // LRU RAM, compacted in place
    logic          lru_we;
    logic [FW-1:0] lru_waddr, lru_raddr, lru_wdata;
    logic [FW-1:0] lru_rdata;
    lbpm_ram #(.WIDTH(FW), .DEPTH(lbpm_pkg::FRAMES)) u_lru (
        .clk(clk), .we(lru_we), .waddr(lru_waddr), .wdata(lru_wdata),
        .raddr(lru_raddr), .rdata(lru_rdata)
    );

    // free queue: frames leave in order and never return, so head is the frame
    // and every frame below the head holds a block
    logic [FW-1:0] free_frame;
    assign free_frame = free_head_reg[FW-1:0];

    logic [FW-1:0] scan_idx, scan_prev;
    assign scan_idx  = scan_reg[FW-1:0];
    assign scan_prev = scan_idx - 1'b1;

    logic is_cmd, slot_ok;
    assign is_cmd  = (req_reg.cmd != lbpm_pkg::CMD_RSVD);
    assign slot_ok = ({3'd0, req_reg.db_id} < 6'(lbpm_pkg::DB_SLOTS));

    // scan pipeline: address scan_idx, then compare the registered tag read of scan_prev
    logic scan_match;
    assign scan_match = (scan_reg != '0) && (LW'(scan_prev) < free_head_reg) &&
                        (tag_rdata == {req_reg.db_id, req_reg.block_id});

    logic [FW-1:0] hf;
    assign hf = hit_frame_reg;

    // pin count and dirty RAMs: read the frame under compare, then hold it
    logic          pin_we;
    logic [FW-1:0] pin_waddr, meta_raddr;
    logic [PW-1:0] pin_wdata, pin_rdata;
    lbpm_ram #(.WIDTH(PW), .DEPTH(lbpm_pkg::FRAMES)) u_pin (
        .clk(clk), .we(pin_we), .waddr(pin_waddr), .wdata(pin_wdata),
        .raddr(meta_raddr), .rdata(pin_rdata)
    );

    logic          dirty_we;
    logic [FW-1:0] dirty_waddr, dirty_raddr;
    logic          dirty_wdata, dirty_rdata;
    lbpm_ram #(.WIDTH(1), .DEPTH(lbpm_pkg::FRAMES)) u_dirty (
        .clk(clk), .we(dirty_we), .waddr(dirty_waddr), .wdata(dirty_wdata),
        .raddr(dirty_raddr), .rdata(dirty_rdata)
    );

    assign meta_raddr  = hit_reg ? hf : scan_prev;
    assign dirty_raddr = evict_reg ? vic_reg : meta_raddr;

    // remove target: hit frame on pin-hit, victim frame (popped head) on eviction
    logic [FW-1:0] rm_frame;
    assign rm_frame = evict_reg ? vic_reg : hf;

    assign tag_raddr = ctl.ev_rd ? vic_reg : scan_idx;
    assign lru_raddr = ctl.pop_rd ? '0 : rd_reg[FW-1:0];

    // compaction step: rd_reg addresses, previous read compared
    logic lru_in;  // a read entry is valid this cycle
    assign lru_in = ctl.lru_step && (rd_reg != '0) && ((rd_reg - 1'b1) < lru_len_reg);
    logic lru_keep;
    assign lru_keep = lru_in && (lru_rdata != rm_frame);

    // final frame of request
    logic [FW-1:0] new_frame;
    assign new_frame = evict_reg ? vic_reg : free_frame;

    logic commit_hit, commit_pin_miss, commit_unpin_zero;
    assign commit_hit        = ctl.commit && is_cmd && slot_ok && hit_reg;
    assign commit_pin_miss   = ctl.commit && is_cmd && slot_ok && sts.miss_pin &&
                               (sts.use_free || evict_reg);
    assign commit_unpin_zero = commit_hit && (req_reg.cmd == lbpm_pkg::CMD_UNPIN) &&
                               (pin_rdata == PW'(1));

    assign tag_we    = commit_pin_miss;
    assign tag_waddr = new_frame;
    assign lru_we    = lru_keep || commit_unpin_zero;
    assign lru_waddr = commit_unpin_zero ? lru_len_reg[FW-1:0] : wr_reg[FW-1:0];
    assign lru_wdata = commit_unpin_zero ? hf : lru_rdata;

    // pin count update: load to 1, saturating raise, lower while above 0
    assign pin_we    = commit_pin_miss ||
                       (commit_hit && req_reg.cmd == lbpm_pkg::CMD_PIN &&
                        pin_rdata != PW'(lbpm_pkg::PIN_MAX)) ||
                       (commit_hit && req_reg.cmd == lbpm_pkg::CMD_UNPIN &&
                        pin_rdata != '0);
    assign pin_waddr = commit_pin_miss ? new_frame : hf;
    assign pin_wdata = commit_pin_miss ? PW'(1) :
                       (req_reg.cmd == lbpm_pkg::CMD_PIN) ? pin_rdata + 1'b1 :
                       pin_rdata - 1'b1;

    // dirty update: clear on load and force, set on a dirty unpin
    assign dirty_we    = commit_pin_miss ||
                         (commit_hit && req_reg.cmd == lbpm_pkg::CMD_UNPIN &&
                          req_reg.made_dirty) ||
                         (commit_hit && req_reg.cmd == lbpm_pkg::CMD_FORCE);
    assign dirty_waddr = commit_pin_miss ? new_frame : hf;
    assign dirty_wdata = commit_hit && (req_reg.cmd == lbpm_pkg::CMD_UNPIN);

    // status to controller
    always_comb
    begin
        sts.need_scan = is_cmd && slot_ok;
        sts.scan_done = (scan_reg == LW'(lbpm_pkg::FRAMES)) || hit_reg || scan_match;
        sts.lru_done  = ctl.lru_step && (rd_reg == lru_len_reg + 1'b1 || rd_reg == '0
                        && lru_len_reg == '0);
        sts.need_lru  = hit_reg && (req_reg.cmd == lbpm_pkg::CMD_PIN) && (pin_rdata == '0);
        sts.miss_pin  = !hit_reg && (req_reg.cmd == lbpm_pkg::CMD_PIN);
        sts.use_free  = (free_len_reg != '0);
        sts.use_lru   = (lru_len_reg != '0);
    end

    // result word
    lbpm_pkg::rsp_t rsp_c;
    always_comb
    begin
        rsp_c = '0;
        if (!is_cmd)
        begin
            rsp_c = '0;
        end
        else if (!slot_ok)
        begin
            rsp_c.status = lbpm_pkg::ST_ABSENT;
        end
        else if (req_reg.cmd == lbpm_pkg::CMD_PIN)
        begin
            if (hit_reg)
            begin
                rsp_c.frame = 6'(hf);
            end
            else if (sts.use_free || evict_reg)
            begin
                rsp_c.status = evict_reg ? lbpm_pkg::ST_EVICT : lbpm_pkg::ST_FREE;
                rsp_c.frame = 6'(new_frame);
                rsp_c.fetch_needed = 1'b1;
                if (evict_reg && dirty_rdata)
                begin
                    rsp_c.writeback = 1'b1;
                    {rsp_c.writeback_db, rsp_c.writeback_block} = vic_tag_reg;
                end
            end
            else
            begin
                rsp_c.status = lbpm_pkg::ST_NOFRAME;
            end
        end
        else if (!hit_reg)
        begin
            rsp_c.status = lbpm_pkg::ST_ABSENT;
        end
        else
        begin
            rsp_c.frame = 6'(hf);
            if (req_reg.cmd == lbpm_pkg::CMD_FORCE && dirty_rdata)
            begin
                rsp_c.writeback = 1'b1;
                rsp_c.writeback_db = req_reg.db_id;
                rsp_c.writeback_block = req_reg.block_id;
            end
        end
    end

    // control registers and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lru_len_reg   <= '0;
            free_len_reg  <= LW'(lbpm_pkg::FRAMES);
            free_head_reg <= '0;
            scan_reg      <= '0;
            rd_reg        <= '0;
            wr_reg        <= '0;
            hit_reg       <= 1'b0;
            evict_reg     <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.commit;
            if (ctl.load)
            begin
                scan_reg  <= '0;
                hit_reg   <= 1'b0;
                evict_reg <= 1'b0;
            end
            if (ctl.scan_step && !sts.scan_done)
            begin
                scan_reg <= scan_reg + 1'b1;
            end
            if (ctl.scan_step && scan_match && !hit_reg)
            begin
                hit_reg <= 1'b1;
            end
            if (ctl.lru_init)
            begin
                rd_reg <= '0;
                wr_reg <= '0;
            end
            if (ctl.lru_step)
            begin
                rd_reg <= rd_reg + 1'b1;
                if (lru_keep) wr_reg <= wr_reg + 1'b1;
                if (sts.lru_done) lru_len_reg <= wr_reg + LW'(lru_keep);
            end
            if (ctl.pop_rd && !sts.use_free)
            begin
                evict_reg <= 1'b1;
            end
            if (commit_pin_miss && !evict_reg)
            begin
                free_len_reg  <= free_len_reg - 1'b1;
                free_head_reg <= free_head_reg + 1'b1;
            end
            if (commit_unpin_zero)
            begin
                lru_len_reg <= lru_len_reg + 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.load) req_reg <= req;
        if (ctl.scan_step && scan_match && !hit_reg) hit_frame_reg <= scan_prev;
        if (evict_reg && !ctl.commit && !ctl.lru_step && !ctl.ev_rd) vic_reg <= lru_rdata;
        if (ctl.lru_init && evict_reg) vic_tag_reg <= tag_rdata;
        if (ctl.commit) rsp_reg <= rsp_c;
    end

    assign result = rsp_reg;
    assign done   = done_reg;

endmodule

// File: rtl/lbpm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbpm_checker: port-level checks
// Result strobes against the request handshake.
// ----------------------------------------------------------------------------
module lbpm_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            busy,
    input  logic            result_valid,
    input  lbpm_pkg::rsp_t  result
);

    // a taken word raises busy next cycle
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("busy not raised");

    // results come only while busy is falling
    a_res: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy && $past(busy)) else $error("stray result");

    // a fetch only on loads
    a_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.fetch_needed |->
        result.status == lbpm_pkg::ST_FREE || result.status == lbpm_pkg::ST_EVICT)
        else $error("bad fetch");

    // no result strobe twice in a row
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid) else $error("double result");

endmodule

bind lru_buffer_pool_manager_top lbpm_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .result_valid(result_valid), .result(result)
);

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: buffer pool frame manager testbench
// Drives pin, unpin, force and reserved requests (directed, then random, mostly
// over a small block set) and checks every result word against a behavioral pool model.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT = 400000;

    // Scoreboard: holds the pool model and the words still owed by the block
    class pool_scoreboard;
        bit          valid_q [lbpm_pkg::FRAMES];
        logic [2:0]  db_q    [lbpm_pkg::FRAMES];
        logic [19:0] blk_q   [lbpm_pkg::FRAMES];
        int          pins    [lbpm_pkg::FRAMES];
        bit          dirty   [lbpm_pkg::FRAMES];
        int          lru_q   [$];
        int          free_q  [$];
        lbpm_pkg::rsp_t owed [$];
        int          errors;

        function new();
            for (int i = 0; i < lbpm_pkg::FRAMES; i++)
            begin
                valid_q[i] = 0;
                pins[i]    = 0;
                dirty[i]   = 0;
                free_q     = {free_q, i};
            end
            errors = 0;
        endfunction

        function int lookup(logic [2:0] db, logic [19:0] blk);
            for (int i = 0; i < lbpm_pkg::FRAMES; i++)
                if (valid_q[i] && db_q[i] == db && blk_q[i] == blk)
                    return i;
            return -1;
        endfunction

        // Advance the model by one accepted request word
        function void note_request(lbpm_pkg::req_t r);
            lbpm_pkg::rsp_t o;
            int   hit;
            int   f;
            o   = '0;
            hit = lookup(r.db_id, r.block_id);
            if (r.cmd == lbpm_pkg::CMD_PIN)
            begin
                if (hit >= 0)
                begin
                    if (pins[hit] == 0)
                        foreach (lru_q[k])
                            if (lru_q[k] == hit)
                            begin
                                lru_q.delete(k);
                                break;
                            end
                    if (pins[hit] < lbpm_pkg::PIN_MAX)
                        pins[hit]++;
                    o.frame = 6'(hit);
                end
                else
                begin
                    f = -1;
                    if (free_q.size() > 0)
                    begin
                        f = free_q[0];
                        free_q.delete(0);
                        o.status = lbpm_pkg::ST_FREE;
                    end
                    else if (lru_q.size() > 0)
                    begin
                        f = lru_q[0];
                        lru_q.delete(0);
                        o.status = lbpm_pkg::ST_EVICT;
                        if (dirty[f])
                        begin
                            o.writeback       = 1'b1;
                            o.writeback_db    = db_q[f];
                            o.writeback_block = blk_q[f];
                        end
                    end
                    else
                        o.status = lbpm_pkg::ST_NOFRAME;
                    if (f >= 0)
                    begin
                        valid_q[f] = 1;
                        db_q[f]    = r.db_id;
                        blk_q[f]   = r.block_id;
                        pins[f]    = 1;
                        dirty[f]   = 0;
                        o.frame    = 6'(f);
                        o.fetch_needed = 1'b1;
                    end
                end
            end
            else if (r.cmd == lbpm_pkg::CMD_UNPIN || r.cmd == lbpm_pkg::CMD_FORCE)
            begin
                if (hit < 0)
                    o.status = lbpm_pkg::ST_ABSENT;
                else if (r.cmd == lbpm_pkg::CMD_UNPIN)
                begin
                    if (r.made_dirty)
                        dirty[hit] = 1;
                    if (pins[hit] > 1)
                        pins[hit]--;
                    else if (pins[hit] == 1)
                    begin
                        pins[hit] = 0;
                        lru_q     = {lru_q, hit};
                    end
                    o.frame = 6'(hit);
                end
                else
                begin
                    if (dirty[hit])
                    begin
                        o.writeback       = 1'b1;
                        o.writeback_db    = r.db_id;
                        o.writeback_block = r.block_id;
                        dirty[hit]        = 0;
                    end
                    o.frame = 6'(hit);
                end
            end
            owed = {owed, o};
        endfunction

        // Compare one result word with the oldest owed word
        function void check_result(lbpm_pkg::rsp_t got);
            lbpm_pkg::rsp_t exp_w;
            if (owed.size() == 0)
            begin
                $display("%0t: unexpected result %h", $realtime, got);
                errors++;
                return;
            end
            exp_w = owed[0];
            owed.delete(0);
            if (got.status != exp_w.status)
                $display("%0t: status exp %0d got %0d", $realtime, exp_w.status, got.status);
            if (got.frame != exp_w.frame)
                $display("%0t: frame exp %0d got %0d", $realtime, exp_w.frame, got.frame);
            if (got.fetch_needed != exp_w.fetch_needed)
                $display("%0t: fetch exp %0b got %0b", $realtime,
                         exp_w.fetch_needed, got.fetch_needed);
            if (got.writeback != exp_w.writeback)
                $display("%0t: writeback exp %0b got %0b", $realtime,
                         exp_w.writeback, got.writeback);
            if (got.writeback_db != exp_w.writeback_db)
                $display("%0t: wb_db exp %0d got %0d", $realtime,
                         exp_w.writeback_db, got.writeback_db);
            if (got.writeback_block != exp_w.writeback_block)
                $display("%0t: wb_block exp %h got %h", $realtime,
                         exp_w.writeback_block, got.writeback_block);
            if (got != exp_w)
                errors++;
        endfunction
    endclass

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    lbpm_pkg::req_t req;
    logic  result_valid;
    lbpm_pkg::rsp_t result;

    pool_scoreboard pool;
    int    cycles;
    int    idle_pct;
    logic [19:0] hot_blocks [16];

    lru_buffer_pool_manager_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req          (req),
        .result_valid (result_valid),
        .result       (result)
    );

    // Clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Check each result word and bound the run
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            pool.check_result(result);
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Send one word: optional idle gap, then hold start until taken
    task automatic send_word(lbpm_pkg::req_t r);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
            @(negedge clk);
        req   <= r;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pool.note_request(r);
        @(negedge clk);
        start <= 1'b0;
    endtask

    task automatic send_fields(logic [1:0] c, logic [2:0] db, logic [19:0] blk,
                               logic dirt);
        lbpm_pkg::req_t r;
        r.cmd        = c;
        r.db_id      = db;
        r.block_id   = blk;
        r.made_dirty = dirt;
        send_word(r);
    endtask

    // Random request, mostly on a small hot set so hits and evictions happen
    task automatic send_random();
        logic [1:0]  c;
        logic [2:0]  db;
        logic [19:0] blk;
        int          pick;
        pick = $urandom_range(99);
        c    = (pick < 45) ? lbpm_pkg::CMD_PIN : (pick < 85) ? lbpm_pkg::CMD_UNPIN :
               (pick < 97) ? lbpm_pkg::CMD_FORCE : lbpm_pkg::CMD_RSVD;
        if ($urandom_range(9) < 8)
        begin
            db  = 3'($urandom_range(1));
            blk = hot_blocks[$urandom_range(15)] + 20'($urandom_range(4));
        end
        else
        begin
            db  = 3'($urandom);
            blk = 20'($urandom);
        end
        send_fields(c, db, blk, 1'($urandom));
    endtask

    task automatic drain();
        while (pool.owed.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        pool     = new();
        cycles   = 0;
        idle_pct = 0;
        rst_n    = 1'b0;
        start    = 1'b0;
        req      = '0;
        for (int i = 0; i < 16; i++)
            hot_blocks[i] = 20'($urandom);
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: absent blocks, extremes, saturation, clean and dirty force
        send_fields(lbpm_pkg::CMD_UNPIN, 3'd7, 20'hFFFFF, 1'b1);
        send_fields(lbpm_pkg::CMD_FORCE, 3'd0, 20'h00000, 1'b0);
        send_fields(lbpm_pkg::CMD_RSVD, 3'd7, 20'hFFFFF, 1'b1);
        send_fields(lbpm_pkg::CMD_PIN, 3'd7, 20'hFFFFF, 1'b0);
        send_fields(lbpm_pkg::CMD_PIN, 3'd0, 20'h00000, 1'b0);
        send_fields(lbpm_pkg::CMD_FORCE, 3'd0, 20'h00000, 1'b0);
        send_fields(lbpm_pkg::CMD_UNPIN, 3'd0, 20'h00000, 1'b1);
        send_fields(lbpm_pkg::CMD_UNPIN, 3'd0, 20'h00000, 1'b0);
        send_fields(lbpm_pkg::CMD_FORCE, 3'd0, 20'h00000, 1'b0);
        send_fields(lbpm_pkg::CMD_FORCE, 3'd0, 20'h00000, 1'b0);
        send_fields(lbpm_pkg::CMD_PIN, 3'd0, 20'h00000, 1'b0);
        for (int i = 0; i < 260; i++)
            send_fields(lbpm_pkg::CMD_PIN, 3'd7, 20'hFFFFF, 1'b0);
        send_fields(lbpm_pkg::CMD_UNPIN, 3'd7, 20'hFFFFF, 1'b1);

        // Fill the pool, then exhaust it, then free and evict
        for (int i = 1; i < lbpm_pkg::FRAMES; i++)
            send_fields(lbpm_pkg::CMD_PIN, 3'd5, 20'(i), 1'b0);
        send_fields(lbpm_pkg::CMD_PIN, 3'd5, 20'h12345, 1'b0);
        for (int i = 1; i < 9; i++)
            send_fields(lbpm_pkg::CMD_UNPIN, 3'd5, 20'(i), i[0]);
        for (int i = 0; i < 9; i++)
            send_fields(lbpm_pkg::CMD_PIN, 3'd6, 20'h80000 + 20'(i), 1'b0);

        // Hold off until all owed words have come
        drain();

        // Random phases with varying idle rates
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = (ph == 0) ? 0 : (ph == 1) ? 58 : (ph == 2) ? 9 : 0;
            for (int i = 0; i < 60; i++)
                send_random();
        end

        drain();
        repeat (2 * lbpm_pkg::FRAMES + 20) @(posedge clk);
        if (pool.errors == 0 && pool.owed.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

// File: lru_buffer_pool_manager_top.f
rtl/lbpm_pkg.sv
rtl/lbpm_ram.sv
rtl/lbpm_ctrl.sv
rtl/lbpm_dp.sv
rtl/lru_buffer_pool_manager_top.sv
rtl/lbpm_checker.sv
test/tb_top.sv
